// ----- sv/wlf_pkg.sv -----
`default_nettype none

package wlf_pkg;

	// Pattern characters with a special meaning, and the line delimiter
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_ANY     = 8'h3F;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// Pattern storage: four 64-bit words of eight characters each
	localparam int PATTERN_WORDS = 4;
	localparam int PATTERN_SLOTS = 32;
	localparam int LENGTH_REG_BITS = 6;
	localparam int OUT_LENGTH_BITS = 16;

	// Configuration register indexes (byte address is 8 times the index)
	localparam logic [2:0] REG_CHARS_A = 3'd0;
	localparam logic [2:0] REG_CHARS_B = 3'd1;
	localparam logic [2:0] REG_CHARS_C = 3'd2;
	localparam logic [2:0] REG_CHARS_D = 3'd3;
	localparam logic [2:0] REG_LENGTH  = 3'd4;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Class of one input beat
	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_NEWLINE,
		KIND_EOF
	} wlf_kind_t;

	typedef struct packed {
		wlf_kind_t   kind;
		logic [7:0]  text_byte;
	} wlf_item_t;

endpackage

`default_nettype wire

// ----- sv/wildcard_line_filter.sv -----
`default_nettype none

// Glob line filter. Text enters one byte per beat on text_byte/end_of_input;
// at each newline, and at end_of_input after a non-empty partial line, one
// result beat reports whether the whole line matched the pattern ('*' any
// run, '?' any one byte), with the line length (saturating) and whether
// end_of_input caused it. The block takes one beat per clock cycle, unless
// a line end waits on a held result: every pattern position is stepped at
// once by the back end's position-vector update. A result passes the front
// register, the queue and the result register after its line-ending beat.
// Pattern registers sit on the APB port at byte address 8*index, 64 bits
// wide; write them only while no line is being judged.
module wildcard_line_filter #(
	parameter int MAX_PATTERN_CHARS = 32,
	parameter int LENGTH_BITS       = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output      logic [63:0] prdata,
	output      logic        pready,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_input,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        line_matched,
	output      logic [15:0] line_length,
	output      logic        final_line
);

	logic [wlf_pkg::PATTERN_WORDS-1:0][63:0]      chars_q;
	logic [wlf_pkg::LENGTH_REG_BITS-1:0]          length_q;
	logic [2:0]                                   reg_index;
	logic                                         cfg_write;

	logic               push_valid;
	logic               push_ready;
	wlf_pkg::wlf_item_t push_item;
	logic               pop_valid;
	logic               pop_ready;
	wlf_pkg::wlf_item_t pop_item;

	assign pready    = 1'b1;
	assign reg_index = paddr[5:3];
	assign cfg_write = psel && penable && pwrite;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q  <= '0;
			length_q <= '0;
		end else if (cfg_write) begin
			case (reg_index)
				wlf_pkg::REG_CHARS_A: chars_q[0] <= pwdata;
				wlf_pkg::REG_CHARS_B: chars_q[1] <= pwdata;
				wlf_pkg::REG_CHARS_C: chars_q[2] <= pwdata;
				wlf_pkg::REG_CHARS_D: chars_q[3] <= pwdata;
				wlf_pkg::REG_LENGTH:  length_q   <= pwdata[wlf_pkg::LENGTH_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Configuration reads
	always_comb begin
		case (reg_index)
			wlf_pkg::REG_CHARS_A: prdata = chars_q[0];
			wlf_pkg::REG_CHARS_B: prdata = chars_q[1];
			wlf_pkg::REG_CHARS_C: prdata = chars_q[2];
			wlf_pkg::REG_CHARS_D: prdata = chars_q[3];
			wlf_pkg::REG_LENGTH:  prdata = 64'(length_q);
			default:              prdata = '0;
		endcase
	end

	wlf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	wlf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	wlf_back #(
		.MAX_PATTERN_CHARS (MAX_PATTERN_CHARS),
		.LENGTH_BITS       (LENGTH_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pattern_chars  (chars_q),
		.pattern_length (length_q),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_item       (pop_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.line_matched   (line_matched),
		.line_length    (line_length),
		.final_line     (final_line)
	);

	a_out_needs_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop_valid) && $past(pop_item.kind) != wlf_pkg::KIND_BYTE)
		else $error("result raised without a line end");

endmodule

`default_nettype wire

// ----- sv/wlf_front.sv -----
`default_nettype none

module wlf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [7:0]         text_byte,
	input  wire logic               end_of_input,
	output      logic               push_valid,
	input  wire logic               push_ready,
	output      wlf_pkg::wlf_item_t push_item
);

	logic               valid_s1;
	wlf_pkg::wlf_item_t item_s1;
	wlf_pkg::wlf_item_t item_class;

	// Classify the incoming beat
	always_comb begin
		item_class.text_byte = text_byte;
		if (end_of_input) begin
			item_class.kind = wlf_pkg::KIND_EOF;
		end else if (text_byte == wlf_pkg::CH_NEWLINE) begin
			item_class.kind = wlf_pkg::KIND_NEWLINE;
		end else begin
			item_class.kind = wlf_pkg::KIND_BYTE;
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// Hold the classified beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_class;
		end
	end

endmodule

`default_nettype wire

// ----- sv/wlf_queue.sv -----
`default_nettype none

module wlf_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output      logic               push_ready,
	input  wire wlf_pkg::wlf_item_t push_item,
	output      logic               pop_valid,
	input  wire logic               pop_ready,
	output      wlf_pkg::wlf_item_t pop_item
);

	localparam int DEPTH = wlf_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	wlf_pkg::wlf_item_t entry_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy above depth");

	a_push_moves_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push without pop did not grow the queue");

endmodule

`default_nettype wire

// ----- sv/wlf_back.sv -----
`default_nettype none

module wlf_back #(
	parameter int MAX_PATTERN_CHARS = 32,
	parameter int LENGTH_BITS       = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic [wlf_pkg::PATTERN_SLOTS*8-1:0]    pattern_chars,
	input  wire logic [wlf_pkg::LENGTH_REG_BITS-1:0]    pattern_length,
	input  wire logic                                   pop_valid,
	output      logic                                   pop_ready,
	input  wire wlf_pkg::wlf_item_t                     pop_item,
	output      logic                                   out_valid,
	input  wire logic                                   out_ready,
	output      logic                                   line_matched,
	output      logic [wlf_pkg::OUT_LENGTH_BITS-1:0]    line_length,
	output      logic                                   final_line
);

	localparam int W  = MAX_PATTERN_CHARS + 1;
	localparam int NW = $clog2(MAX_PATTERN_CHARS + 1);
	localparam int LV = $clog2(MAX_PATTERN_CHARS + 1);

	logic [W-1:0]             pos_q;
	logic [LENGTH_BITS-1:0]   cnt_q;
	logic                     out_valid_q;
	logic                     matched_q;
	logic [wlf_pkg::OUT_LENGTH_BITS-1:0] length_q;
	logic                     final_q;

	logic [NW-1:0]                n_used;
	logic [MAX_PATTERN_CHARS-1:0] in_use;
	logic [MAX_PATTERN_CHARS-1:0] is_star;
	logic [MAX_PATTERN_CHARS-1:0] is_hit;
	logic [W-1:0]                 gen_l [LV+1];
	logic [W-1:0]                 prop_l [LV+1];
	logic [W-1:0]                 closed;
	logic [W-1:0]                 pos_next;
	logic                         line_end;
	logic                         has_result;
	logic                         pop;

	// Clamp the pattern length to the supported maximum
	always_comb begin
		if (pattern_length > wlf_pkg::LENGTH_REG_BITS'(MAX_PATTERN_CHARS)) begin
			n_used = NW'(MAX_PATTERN_CHARS);
		end else begin
			n_used = NW'(pattern_length);
		end
	end

	// Per-position character tests against the current byte
	always_comb begin
		for (int i = 0; i < MAX_PATTERN_CHARS; i++) begin
			in_use[i]  = (32'(i) < 32'(n_used));
			is_star[i] = (pattern_chars[i*8 +: 8] == wlf_pkg::CH_STAR);
			is_hit[i]  = !is_star[i] && ((pattern_chars[i*8 +: 8] == wlf_pkg::CH_ANY) ||
				(pattern_chars[i*8 +: 8] == pop_item.text_byte));
		end
	end

	// Star closure as a parallel prefix: an active position before a star
	// enables the position after it, transitively
	always_comb begin
		gen_l[0]  = pos_q;
		prop_l[0] = {is_star, 1'b0};
		for (int l = 0; l < LV; l++) begin
			for (int j = 0; j < W; j++) begin
				if (j >= (1 << l)) begin
					gen_l[l+1][j]  = gen_l[l][j] | (prop_l[l][j] & gen_l[l][j - (1 << l)]);
					prop_l[l+1][j] = prop_l[l][j] & prop_l[l][j - (1 << l)];
				end else begin
					gen_l[l+1][j]  = gen_l[l][j];
					prop_l[l+1][j] = prop_l[l][j];
				end
			end
		end
		closed = gen_l[LV];
	end

	// Step every active position over the byte
	always_comb begin
		pos_next = '0;
		for (int i = 0; i < MAX_PATTERN_CHARS; i++) begin
			if (in_use[i] && closed[i]) begin
				if (is_star[i]) begin
					pos_next[i] = 1'b1;
				end
				if (is_hit[i]) begin
					pos_next[i+1] = 1'b1;
				end
			end
		end
	end

	assign line_end   = (pop_item.kind != wlf_pkg::KIND_BYTE);
	assign has_result = (pop_item.kind == wlf_pkg::KIND_NEWLINE) ||
		((pop_item.kind == wlf_pkg::KIND_EOF) && (cnt_q != '0));
	assign pop_ready  = !line_end || !out_valid_q || out_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance match state and line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= W'(1);
			cnt_q <= '0;
		end else if (pop) begin
			if (line_end) begin
				pos_q <= W'(1);
				cnt_q <= '0;
			end else begin
				pos_q <= pos_next;
				if (cnt_q != '1) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && line_end && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && line_end && has_result) begin
			matched_q <= closed[n_used];
			length_q  <= wlf_pkg::OUT_LENGTH_BITS'(cnt_q);
			final_q   <= (pop_item.kind == wlf_pkg::KIND_EOF);
		end
	end

	assign out_valid    = out_valid_q;
	assign line_matched = matched_q;
	assign line_length  = length_q;
	assign final_line   = final_q;

	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && line_end) |=> (pos_q == W'(1)) && (cnt_q == '0))
		else $error("line end did not restart the match state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && line_end && has_result) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !line_end) |=> (pos_q != '0) || ($past(closed) & $past({1'b0, in_use})) == '0
		|| $past(pos_next) == '0)
		else $error("position vector update lost");

endmodule

`default_nettype wire

// ----- dv/wildcard_line_filter_tb.sv -----
module wildcard_line_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Register index with no register behind it
	localparam logic [2:0] REG_UNMAPPED = 3'd6;
	localparam logic [2:0] CHAR_REGS [wlf_pkg::PATTERN_WORDS] =
		'{wlf_pkg::REG_CHARS_A, wlf_pkg::REG_CHARS_B, wlf_pkg::REG_CHARS_C,
		wlf_pkg::REG_CHARS_D};
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [15:0] LINE_BYTES_MAX = 16'hFFFF;
	// Cycles to let the pipeline empty after the last result
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BEATS = 38;
	localparam int RANDOM_PHASES = 8;

	typedef struct {
		logic        matched;
		logic [15:0] nbytes;
		logic        at_eof;
	} line_verdict_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  text_byte;
	logic        end_of_input;
	logic        out_valid;
	logic        out_ready;
	logic        line_matched;
	logic [15:0] line_length;
	logic        final_line;

	// Shadow of the pattern registers and the line state
	logic [63:0] pat_word [wlf_pkg::PATTERN_WORDS];
	logic [5:0]  pat_len_reg;
	logic [32:0] live_pos;
	logic [15:0] line_bytes;
	logic [7:0]  pat_text [wlf_pkg::PATTERN_SLOTS];

	line_verdict_t pending_lines [$];
	int mismatch_count = 0;
	int hold_off = 0;
	bit quiet = 1'b0;

	wildcard_line_filter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_matched (line_matched),
		.line_length  (line_length),
		.final_line   (final_line)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [7:0] pat_char(int i);
		return pat_word[i / 8][(i % 8) * 8 +: 8];
	endfunction

	// Advance the position vector by one beat and queue the verdict a line end gives
	function automatic void step_glob_match(logic [7:0] b, logic eof);
		int n;
		logic [32:0] v;
		logic [32:0] nxt;
		line_verdict_t r;
		n = (pat_len_reg > wlf_pkg::PATTERN_SLOTS) ? wlf_pkg::PATTERN_SLOTS :
			int'(pat_len_reg);
		v = live_pos;
		// a live position in front of a star also enables the one after it
		for (int i = 0; i < n; i++)
			if (v[i] && pat_char(i) == wlf_pkg::CH_STAR)
				v[i + 1] = 1'b1;
		if (eof || b == wlf_pkg::CH_NEWLINE) begin
			if (!eof || line_bytes != 0) begin
				r.matched = v[n];
				r.nbytes = line_bytes;
				r.at_eof = eof;
				pending_lines.push_back(r);
			end
			live_pos = 33'd1;
			line_bytes = '0;
		end else begin
			nxt = '0;
			for (int i = 0; i < n; i++) begin
				if (v[i]) begin
					if (pat_char(i) == wlf_pkg::CH_STAR)
						nxt[i] = 1'b1;
					else if (pat_char(i) == wlf_pkg::CH_ANY || pat_char(i) == b)
						nxt[i + 1] = 1'b1;
				end
			end
			live_pos = nxt;
			if (line_bytes != LINE_BYTES_MAX)
				line_bytes = line_bytes + 1'b1;
		end
	endfunction

	// Mostly a small alphabet so stars and literals compete; never a newline
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		if ($urandom_range(0, 1))
			return CH_LOWER_A + 8'($urandom_range(0, 2));
		b = 8'($urandom_range(0, 255));
		return (b == wlf_pkg::CH_NEWLINE) ? wlf_pkg::CH_ANY : b;
	endfunction

	function automatic void fill_pattern(string s);
		for (int i = 0; i < wlf_pkg::PATTERN_SLOTS; i++)
			pat_text[i] = (i < s.len()) ? s[i] : 8'($urandom_range(0, 255));
	endfunction

	// Offer one beat, hold it until accepted, then update the prediction
	task automatic send_beat(logic [7:0] b, logic eof);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_input <= eof;
		do @(posedge clk); while (!in_ready);
		step_glob_match(b, eof);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	task automatic send_eof();
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Drop valid and wait until every verdict is out and the pipeline is empty
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == wlf_pkg::REG_LENGTH)
			pat_len_reg = value[5:0];
		else if (idx <= wlf_pkg::REG_CHARS_D)
			pat_word[idx[1:0]] = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Read a register back and compare it with the shadow value
	task automatic check_reg(logic [2:0] idx, logic [63:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 3'b000};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: register %0d read expected %0h actual %0h",
				$time, idx, want, prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Load pat_text and a length code once the block is idle
	task automatic program_pattern(logic [5:0] len_code);
		logic [63:0] w;
		logic [63:0] len_word;
		settle_block();
		for (int k = 0; k < wlf_pkg::PATTERN_WORDS; k++) begin
			for (int j = 0; j < 8; j++)
				w[j * 8 +: 8] = pat_text[k * 8 + j];
			write_reg(CHAR_REGS[k], w);
		end
		len_word = {$urandom(), $urandom()};
		len_word[5:0] = len_code;
		write_reg(wlf_pkg::REG_LENGTH, len_word);
		check_reg(wlf_pkg::REG_CHARS_A, pat_word[0]);
		check_reg(wlf_pkg::REG_LENGTH, {58'd0, len_code});
	endtask

	// Empty lines, end of input on partial and empty lines, restart after it
	task automatic test_stream_ends();
		send_text("\n");
		send_text("ab");
		send_eof();
		send_eof();
		send_text("\n");
		settle_block();
	endtask

	task automatic test_wildcards();
		fill_pattern("a?*c");
		program_pattern(6'd4);
		send_text("abc\naxyzc\nac\n");
	endtask

	// A length code above the slot count acts as the full pattern
	task automatic test_length_overrange();
		for (int i = 0; i < wlf_pkg::PATTERN_SLOTS; i++)
			pat_text[i] = wlf_pkg::CH_STAR;
		program_pattern(6'd63);
		send_text("\nq\n");
	endtask

	// Rewrite the pattern in the middle of a line; the live vector carries on
	task automatic test_midline_write();
		fill_pattern("abc");
		program_pattern(6'd3);
		send_text("ab");
		fill_pattern("abd");
		program_pattern(6'd3);
		write_reg(REG_UNMAPPED, {$urandom(), $urandom()});
		send_text("d\nabc\n");
	endtask

	// Hold the result side off while short lines keep coming
	task automatic test_output_stall();
		fill_pattern("x*");
		program_pattern(6'd2);
		hold_off = 80;
		repeat (20) begin
			if ($urandom_range(0, 1))
				send_text("x");
			repeat ($urandom_range(0, 2)) send_beat(pick_byte(), 1'b0);
			send_beat(wlf_pkg::CH_NEWLINE, 1'b0);
		end
		settle_block();
	endtask

	// Mostly lines built to fit the pattern, some damaged, some noise
	task automatic test_random_lines();
		logic [7:0] line_q [$];
		logic [5:0] len_code;
		int n;
		int sent;
		int roll;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					len_code = 6'(wlf_pkg::PATTERN_SLOTS);
				end
				1: begin
					len_code = 6'($urandom_range(wlf_pkg::PATTERN_SLOTS + 1, 63));
				end
				2: begin
					len_code = '0;
				end
				default: begin
					len_code = 6'($urandom_range(1, 10));
				end
			endcase
			for (int i = 0; i < wlf_pkg::PATTERN_SLOTS; i++) begin
				roll = $urandom_range(0, 9);
				if (roll < 2)
					pat_text[i] = wlf_pkg::CH_STAR;
				else if (roll < 4)
					pat_text[i] = wlf_pkg::CH_ANY;
				else if (roll == 9)
					pat_text[i] = 8'($urandom_range(0, 255));
				else
					pat_text[i] = CH_LOWER_A + 8'($urandom_range(0, 2));
			end
			program_pattern(len_code);
			// last phase runs with no idling on either side
			if (phase == RANDOM_PHASES - 1)
				quiet = 1'b1;
			n = (len_code > wlf_pkg::PATTERN_SLOTS) ? wlf_pkg::PATTERN_SLOTS :
				int'(len_code);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				line_q.delete();
				roll = $urandom_range(0, 15);
				if (roll == 0) begin
					repeat ($urandom_range(0, 6)) line_q.push_back(pick_byte());
				end else begin
					for (int i = 0; i < n; i++) begin
						if (pat_text[i] == wlf_pkg::CH_STAR)
							repeat ($urandom_range(0, 3)) line_q.push_back(pick_byte());
						else if (pat_text[i] == wlf_pkg::CH_ANY)
							line_q.push_back(pick_byte());
						else
							line_q.push_back(pat_text[i]);
					end
					// damage some lines: change, drop or add one byte
					if (roll < 4 && line_q.size() > 0)
						line_q[$urandom_range(0, line_q.size() - 1)] = pick_byte();
					else if (roll == 4 && line_q.size() > 0)
						line_q.delete($urandom_range(0, line_q.size() - 1));
					else if (roll == 5)
						line_q.insert($urandom_range(0, line_q.size()), pick_byte());
				end
				foreach (line_q[i])
					send_beat(line_q[i], 1'b0);
				sent += line_q.size() + 1;
				roll = $urandom_range(0, 7);
				if (roll == 0) begin
					send_eof();
				end else begin
					send_beat(wlf_pkg::CH_NEWLINE, 1'b0);
					if (roll == 1) begin
						send_eof();
						sent++;
					end
				end
			end
		end
	endtask

	// Result side: random stall bursts, plus a long hold-off on request
	initial begin
		int burst;
		burst = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 4) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each result beat with the oldest predicted verdict
	always @(posedge clk) begin : check_result
		line_verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_lines.size() == 0) begin
				$display("%0t: result beat with none expected (matched %0d length %0d final %0d)",
					$time, line_matched, line_length, final_line);
				mismatch_count++;
			end else begin
				want = pending_lines.pop_front();
				if (line_matched !== want.matched) begin
					$display("%0t: line_matched expected %0d actual %0d",
						$time, want.matched, line_matched);
					mismatch_count++;
				end
				if (line_length !== want.nbytes) begin
					$display("%0t: line_length expected %0d actual %0d",
						$time, want.nbytes, line_length);
					mismatch_count++;
				end
				if (final_line !== want.at_eof) begin
					$display("%0t: final_line expected %0d actual %0d",
						$time, want.at_eof, final_line);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		text_byte = '0;
		end_of_input = 1'b0;
		for (int k = 0; k < wlf_pkg::PATTERN_WORDS; k++)
			pat_word[k] = '0;
		pat_len_reg = '0;
		live_pos = 33'd1;
		line_bytes = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_stream_ends();
		test_wildcards();
		test_length_overrange();
		test_midline_write();
		test_output_stall();
		test_random_lines();
		settle_block();

		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
